// File: sv/palette_pixel_upscaler_top_assert.svh
// assertion macros shared by the checker
`ifndef PALETTE_PIXEL_UPSCALER_TOP_ASSERT_SVH
`define PALETTE_PIXEL_UPSCALER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PPU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette pixel upscaler check failed");

// next-cycle implication, checked outside reset
`define PPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette pixel upscaler check failed");

`endif

// File: sv/ppu_pkg.sv
package ppu_pkg;

    // fixed field widths
    localparam int CFG_W     = 13;
    localparam int COORD_W   = 12;
    localparam int POS_W     = 12;
    localparam int RUN_W     = 4;
    localparam int IDX_W     = 8;
    localparam int CHAN_W    = 8;
    localparam int RGB_W     = 3 * CHAN_W;
    localparam int WORD_W    = 32;
    localparam int S_DATA_W  = 32;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 64;
    localparam int CFG_IDX_W = 2;

    // dimension limits
    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);

    // colour store
    localparam int PALETTE_SIZE = 256;
    localparam logic [CHAN_W-1:0] ALPHA = 8'hFF;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command codes
    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_PIXEL   = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT  = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 13'd320;
    localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 13'd240;
    localparam logic [CFG_W-1:0] RST_FB_WIDTH   = 13'd640;
    localparam logic [CFG_W-1:0] RST_FB_HEIGHT  = 13'd480;

    // one classified pixel waiting for the back end
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [RGB_W-1:0]   rgb;
        logic               frame_end;
    } t_job;

    // limit a register value to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

endpackage

// File: sv/palette_pixel_upscaler_top.sv
// palette pixel upscaler
// slave stream takes palette writes and indexed pixels; tuser[0] picks the
// kind (0 palette write, 1 pixel), tuser[1] restarts the raster position.
// each pixel gives one run per replicated destination row on the master
// stream, top row first; tlast marks the pixel's last run and tuser marks
// the last run of the frame's final pixel.
// the config channel writes the four dimension registers, always ready; the user
// must write it only while the block is idle: the block itself does not enforce it.
// a pixel passes stage a (position/palette read), stage b (scaling products)
// and the offset add into the queue before the back end registers its first run.
// throughput: one run per cycle from the back end while the receiver keeps up,
// so a pixel gives scale runs; a palette write produces nothing.
// the front keeps accepting while runs wait, as long as the four-entry job
// queue has room for the pixels already in flight.
// a stalled receiver holds the output register; the queue then fills and the
// slave side drops tready.
// reset: palette reads as zero through per-entry valid bits (no clearing
// pass), position at column 0 row 0, registers 320x240 into 640x480.
module palette_pixel_upscaler_top import ppu_pkg::*; #(
    parameter int MAX_SCALE = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,   // color_index, red, green, blue
    input  logic [S_USER_W-1:0]  s_axis_tuser,   // cmd, frame_start
    // master stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_DATA_W-1:0]  m_axis_tdata,   // dst_x, dst_y, run_length, pixel_word
    output logic                 m_axis_tlast,   // last_of_item
    output logic                 m_axis_tuser,   // frame_done
    // config channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SCALE_W = $clog2(MAX_SCALE + 1);

    logic               w_q_push, w_q_pop, w_q_valid;
    t_job               w_q_in, w_q_head;
    logic [QCNT_W-1:0]  w_q_count;
    logic [SCALE_W-1:0] w_scale;

    // registers take a write on any cycle
    assign o_cfg_ready = 1'b1;

    // front: accept, track position, read colour, compute start coordinates
    ppu_front #(
        .MAX_SCALE (MAX_SCALE),
        .SCALE_W   (SCALE_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_count   (w_q_count),
        .o_q_push    (w_q_push),
        .o_q_job     (w_q_in),
        .o_scale     (w_scale)
    );

    // job queue between the two halves
    ppu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_head),
        .o_count (w_q_count)
    );

    // back: one row run per cycle into the output register while the receiver keeps up
    ppu_back #(
        .MAX_SCALE (MAX_SCALE),
        .SCALE_W   (SCALE_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_job    (w_q_head),
        .o_q_pop    (w_q_pop),
        .i_scale    (w_scale),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

// File: sv/ppu_ram.sv
module ppu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ppu_fifo.sv
module ppu_fifo import ppu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_job              i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output t_job              o_data,
    output logic [QCNT_W-1:0] o_count
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_pop;

    // pop only when something is held
    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= QPTR_W'((32'(r_wr_ptr) + 1) % QUEUE_DEPTH);
            end
            if (w_pop) begin
                r_rd_ptr <= QPTR_W'((32'(r_rd_ptr) + 1) % QUEUE_DEPTH);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: sv/ppu_front.sv
module ppu_front import ppu_pkg::*; #(
    parameter int MAX_SCALE = 8,
    parameter int SCALE_W   = $clog2(MAX_SCALE + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_DATA_W-1:0]  i_s_tdata,
    input  logic [S_USER_W-1:0]  i_s_tuser,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [QCNT_W-1:0]    i_q_count,
    output logic                 o_q_push,
    output t_job                 o_q_job,
    output logic [SCALE_W-1:0]   o_scale
);

    localparam int PROD_W = DIM_W + SCALE_W;
    localparam int PPOS_W = POS_W + SCALE_W;
    localparam int CMP_W  = DIM_W + 1;
    localparam int SUM_W  = PPOS_W + 1;
    localparam int PAL_AW = $clog2(PALETTE_SIZE);

    // configuration
    logic [CFG_W-1:0] r_src_w, r_src_h, r_fb_w, r_fb_h;
    logic [DIM_W-1:0] w_sw, w_sh, w_fw, w_fh;

    // derived geometry
    logic [SCALE_W-1:0] r_scale, n_scale;
    logic [DIM_W-1:0]   r_off_x, r_off_y;
    logic [PROD_W-1:0]  w_px_try, w_py_try, w_span_x, w_span_y;

    // source position
    logic [POS_W-1:0] r_col, r_row;
    logic [POS_W-1:0] w_cur_col, w_cur_row;
    logic             w_col_wrap, w_row_wrap;

    // request fields
    logic              w_accept, w_cmd, w_fs;
    logic [IDX_W-1:0]  w_idx;
    logic [RGB_W-1:0]  w_rgb;

    // colour store
    logic [PALETTE_SIZE-1:0] r_pal_vld;
    logic [RGB_W-1:0]        w_pal_rdata;
    logic                    w_pal_we;

    // stage a: position and palette read
    logic             r_a_valid, r_a_fend, r_a_pv;
    logic [POS_W-1:0] r_a_col, r_a_row;

    // stage b: products and colour
    logic              r_b_valid, r_b_fend;
    logic [PPOS_W-1:0] r_b_px, r_b_py;
    logic [RGB_W-1:0]  r_b_rgb;

    logic [QCNT_W:0]  w_load;
    logic [SUM_W-1:0] w_x_sum, w_y_sum;

    assign w_cmd = i_s_tuser[0];
    assign w_fs  = i_s_tuser[1];
    assign w_idx = i_s_tdata[IDX_W-1:0];
    assign w_rgb = {i_s_tdata[15:8], i_s_tdata[23:16], i_s_tdata[31:24]};

    // credit check: queue entries plus pixels still in the two stages
    assign w_load     = (QCNT_W+1)'(i_q_count) + (QCNT_W+1)'(r_a_valid)
                      + (QCNT_W+1)'(r_b_valid);
    assign o_s_tready = (w_load < (QCNT_W+1)'(QUEUE_DEPTH));
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_WIDTH;
            r_src_h <= RST_SRC_HEIGHT;
            r_fb_w  <= RST_FB_WIDTH;
            r_fb_h  <= RST_FB_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                REG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                REG_FB_WIDTH:   r_fb_w  <= i_cfg_data;
                REG_FB_HEIGHT:  r_fb_h  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_sw = clamp_dim(r_src_w);
    assign w_sh = clamp_dim(r_src_h);
    assign w_fw = clamp_dim(r_fb_w);
    assign w_fh = clamp_dim(r_fb_h);

    // largest scale that fits both axes, tried in parallel
    always_comb begin
        n_scale  = SCALE_W'(1);
        w_px_try = '0;
        w_py_try = '0;
        for (int s = 2; s <= MAX_SCALE; s++) begin
            w_px_try = PROD_W'(w_sw) * PROD_W'(s);
            w_py_try = PROD_W'(w_sh) * PROD_W'(s);
            if ((w_px_try <= PROD_W'(w_fw)) && (w_py_try <= PROD_W'(w_fh))) begin
                n_scale = SCALE_W'(s);
            end
        end
    end

    assign w_span_x = PROD_W'(w_sw) * PROD_W'(r_scale);
    assign w_span_y = PROD_W'(w_sh) * PROD_W'(r_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(1);
            r_off_x <= '0;
            r_off_y <= '0;
        end else begin
            r_scale <= n_scale;
            r_off_x <= (w_span_x >= PROD_W'(w_fw)) ? '0
                     : DIM_W'((PROD_W'(w_fw) - w_span_x) >> 1);
            r_off_y <= (w_span_y >= PROD_W'(w_fh)) ? '0
                     : DIM_W'((PROD_W'(w_fh) - w_span_y) >> 1);
        end
    end

    // raster position, frame start applies before the request
    assign w_cur_col  = w_fs ? '0 : r_col;
    assign w_cur_row  = w_fs ? '0 : r_row;
    assign w_col_wrap = (CMP_W'(w_cur_col) + CMP_W'(1)) >= CMP_W'(w_sw);
    assign w_row_wrap = (CMP_W'(w_cur_row) + CMP_W'(1)) >= CMP_W'(w_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_cmd == CMD_PIXEL) begin
                if (w_col_wrap) begin
                    r_col <= '0;
                    r_row <= w_row_wrap ? '0 : w_cur_row + POS_W'(1);
                end else begin
                    r_col <= w_cur_col + POS_W'(1);
                    r_row <= w_cur_row;
                end
            end else begin
                r_col <= w_cur_col;
                r_row <= w_cur_row;
            end
        end
    end

    // colour store, entries not yet written read as zero
    assign w_pal_we = w_accept && (w_cmd == CMD_PALETTE);

    ppu_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PALETTE_SIZE)
    ) u_pal (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (PAL_AW'(w_idx)),
        .i_wdata (w_rgb),
        .i_raddr (PAL_AW'(w_idx)),
        .o_rdata (w_pal_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_vld <= '0;
        end else if (w_pal_we) begin
            r_pal_vld[PAL_AW'(w_idx)] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept && (w_cmd == CMD_PIXEL);
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_col  <= w_cur_col;
        r_a_row  <= w_cur_row;
        r_a_fend <= w_col_wrap && w_row_wrap;
        r_a_pv   <= r_pal_vld[PAL_AW'(w_idx)];
        r_b_px   <= PPOS_W'(r_a_col) * PPOS_W'(r_scale);
        r_b_py   <= PPOS_W'(r_a_row) * PPOS_W'(r_scale);
        r_b_rgb  <= r_a_pv ? w_pal_rdata : '0;
        r_b_fend <= r_a_fend;
    end

    assign w_x_sum = SUM_W'(r_off_x) + SUM_W'(r_b_px);
    assign w_y_sum = SUM_W'(r_off_y) + SUM_W'(r_b_py);

    assign o_q_push            = r_b_valid;
    assign o_q_job.x0          = w_x_sum[COORD_W-1:0];
    assign o_q_job.y0          = w_y_sum[COORD_W-1:0];
    assign o_q_job.rgb         = r_b_rgb;
    assign o_q_job.frame_end   = r_b_fend;
    assign o_scale             = r_scale;

endmodule

// File: sv/ppu_back.sv
module ppu_back import ppu_pkg::*; #(
    parameter int MAX_SCALE = 8,
    parameter int SCALE_W   = $clog2(MAX_SCALE + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_job                i_q_job,
    output logic                o_q_pop,
    input  logic [SCALE_W-1:0]  i_scale,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tlast,
    output logic                o_m_tuser
);

    logic [SCALE_W-1:0] r_k;
    logic               r_m_valid;
    logic [COORD_W-1:0] r_x, r_y;
    logic [RUN_W-1:0]   r_run;
    logic [WORD_W-1:0]  r_word;
    logic               r_last, r_fdone;
    logic               w_load, w_last;

    assign w_load = (!r_m_valid || i_m_tready) && i_q_valid;
    assign w_last = ((SCALE_W+1)'(r_k) + (SCALE_W+1)'(1)) == (SCALE_W+1)'(i_scale);

    // the job leaves the queue with its final row
    assign o_q_pop = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_k       <= '0;
        end else begin
            if (w_load) begin
                r_m_valid <= 1'b1;
                r_k       <= w_last ? '0 : r_k + SCALE_W'(1);
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x     <= i_q_job.x0;
            r_y     <= i_q_job.y0 + COORD_W'(r_k);
            r_run   <= RUN_W'(i_scale);
            r_word  <= {ALPHA, i_q_job.rgb};
            r_last  <= w_last;
            r_fdone <= w_last && i_q_job.frame_end;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(M_DATA_W - WORD_W - RUN_W - 2*COORD_W){1'b0}},
                         r_word, r_run, r_y, r_x};
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_fdone;

endmodule

// File: sv/ppu_checker.sv
`include "palette_pixel_upscaler_top_assert.svh"

module ppu_checker import ppu_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tlast,
    input logic                m_axis_tuser
);

    // a held result keeps its payload
    `PPU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // frame end only on a pixel's last run
    `PPU_ASSERT_NOW(a_fdone_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

    // rows of one pixel follow at once, one row further down, same column
    `PPU_ASSERT_NEXT(a_next_row, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[23:12] == 12'($past(m_axis_tdata[23:12]) + 12'd1)) && (m_axis_tdata[11:0] == $past(m_axis_tdata[11:0])))

endmodule

bind palette_pixel_upscaler_top ppu_checker u_ppu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: bench/tb.sv
module tb;
    import ppu_pkg::*;

    localparam int SCALE_CAP    = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 12;      // margin beyond the pipeline
    localparam int HOLD_AT      = 40;      // requests taken before the long sink hold-off
    localparam int LONG_HOLD    = 120;
    localparam int RAND_PHASES  = 5;
    localparam int RAND_ITEMS   = 26;
    localparam int MAX_PRINTS   = 40;

    // master tdata layout, lowest bit first
    localparam int X_LSB    = 0;
    localparam int Y_LSB    = X_LSB + COORD_W;
    localparam int LEN_LSB  = Y_LSB + COORD_W;
    localparam int WORD_LSB = LEN_LSB + RUN_W;
    localparam int PAD_LSB  = WORD_LSB + WORD_W;
    localparam int PAD_W    = M_DATA_W - PAD_LSB;

    typedef struct packed {
        logic              cmd;
        logic              fs;
        logic [IDX_W-1:0]  idx;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_req;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RUN_W-1:0]   len;
        logic [WORD_W-1:0]  word;
        logic               last;
        logic               done;
    } t_run;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [S_USER_W-1:0]  s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = REG_SRC_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    palette_pixel_upscaler_top #(.MAX_SCALE(SCALE_CAP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // requests waiting to be offered, and runs still owed by the block
    t_req req_queue[$];
    t_run owed_runs[$];

    // shadow of the block: colour store, raster position, dimension registers
    logic [RGB_W-1:0] colour_lut [PALETTE_SIZE];
    int unsigned      cur_col;
    int unsigned      cur_row;
    logic [CFG_W-1:0] reg_src_w = RST_SRC_WIDTH;
    logic [CFG_W-1:0] reg_src_h = RST_SRC_HEIGHT;
    logic [CFG_W-1:0] reg_fb_w  = RST_FB_WIDTH;
    logic [CFG_W-1:0] reg_fb_h  = RST_FB_HEIGHT;

    int          err_cnt   = 0;
    int unsigned cycle_cnt = 0;
    int unsigned req_count = 0;
    bit          idle_on   = 1'b1;

    initial begin
        foreach (colour_lut[i]) colour_lut[i] = '0;
        cur_col = 0;
        cur_row = 0;
    end

    function automatic int unsigned dim_in_use(input logic [CFG_W-1:0] v);
        int unsigned d;
        d = 32'(v);
        if (d == 0) d = 1;
        else if (d > MAX_DIM) d = MAX_DIM;
        return d;
    endfunction

    function automatic int unsigned centring(input int unsigned fb, input int unsigned span);
        return (span >= fb) ? 0 : (fb - span) / 2;
    endfunction

    // applies one request to the shadow state and queues the runs it owes
    function automatic void upscale_request(input t_req rq);
        int unsigned sw, sh, fw, fh, scale, ox, oy, x0, y0;
        logic        frame_end;
        t_run        run;
        if (rq.fs) begin
            cur_col = 0;
            cur_row = 0;
        end
        if (rq.cmd == CMD_PALETTE) begin
            colour_lut[rq.idx] = {rq.red, rq.green, rq.blue};
            return;
        end
        sw = dim_in_use(reg_src_w);
        sh = dim_in_use(reg_src_h);
        fw = dim_in_use(reg_fb_w);
        fh = dim_in_use(reg_fb_h);
        scale = fw / sw;
        if (fh / sh < scale) scale = fh / sh;
        if (scale < 1) scale = 1;
        if (scale > SCALE_CAP) scale = SCALE_CAP;
        ox = centring(fw, sw * scale);
        oy = centring(fh, sh * scale);
        x0 = ox + cur_col * scale;
        y0 = oy + cur_row * scale;
        // greater-or-equal wrap: a position left beyond a shrunk source wraps at once
        frame_end = 1'b0;
        if (cur_col + 1 >= sw) begin
            cur_col = 0;
            if (cur_row + 1 >= sh) begin
                cur_row   = 0;
                frame_end = 1'b1;
            end else begin
                cur_row = (cur_row + 1) & 12'hFFF;
            end
        end else begin
            cur_col = (cur_col + 1) & 12'hFFF;
        end
        for (int unsigned k = 0; k < scale; k++) begin
            run.x    = COORD_W'(x0);
            run.y    = COORD_W'(y0 + k);
            run.len  = RUN_W'(scale);
            run.word = {ALPHA, colour_lut[rq.idx]};
            run.last = (k + 1 == scale);
            run.done = (k + 1 == scale) && frame_end;
            owed_runs.push_back(run);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_cnt < MAX_PRINTS)
            $display("mismatch on %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    task automatic check_run();
        t_run want;
        if (owed_runs.size() == 0) begin
            report_mismatch("run with nothing owed", m_axis_tdata[31:0], 32'h0);
        end else begin
            want = owed_runs.pop_front();
            if (m_axis_tdata[X_LSB +: COORD_W] !== want.x)
                report_mismatch("dst_x", 32'(m_axis_tdata[X_LSB +: COORD_W]), 32'(want.x));
            if (m_axis_tdata[Y_LSB +: COORD_W] !== want.y)
                report_mismatch("dst_y", 32'(m_axis_tdata[Y_LSB +: COORD_W]), 32'(want.y));
            if (m_axis_tdata[LEN_LSB +: RUN_W] !== want.len)
                report_mismatch("run_length", 32'(m_axis_tdata[LEN_LSB +: RUN_W]),
                                32'(want.len));
            if (m_axis_tdata[WORD_LSB +: WORD_W] !== want.word)
                report_mismatch("pixel_word", m_axis_tdata[WORD_LSB +: WORD_W], want.word);
            if (m_axis_tdata[PAD_LSB +: PAD_W] !== '0)
                report_mismatch("tdata padding", 32'(m_axis_tdata[PAD_LSB +: PAD_W]), 32'h0);
            if (m_axis_tlast !== want.last)
                report_mismatch("last_of_item", 32'(m_axis_tlast), 32'(want.last));
            if (m_axis_tuser !== want.done)
                report_mismatch("frame_done", 32'(m_axis_tuser), 32'(want.done));
        end
    endtask

    // monitor: register writes, accepted requests and accepted runs
    always @(posedge i_clk) begin : monitor
        t_req rq;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SRC_WIDTH:  reg_src_w = i_cfg_data;
                    REG_SRC_HEIGHT: reg_src_h = i_cfg_data;
                    REG_FB_WIDTH:   reg_fb_w  = i_cfg_data;
                    REG_FB_HEIGHT:  reg_fb_h  = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                check_run();
            if (s_axis_tvalid && s_axis_tready) begin
                rq.cmd   = s_axis_tuser[0];
                rq.fs    = s_axis_tuser[1];
                rq.idx   = s_axis_tdata[0 +: IDX_W];
                rq.red   = s_axis_tdata[8 +: CHAN_W];
                rq.green = s_axis_tdata[16 +: CHAN_W];
                rq.blue  = s_axis_tdata[24 +: CHAN_W];
                upscale_request(rq);
                req_count <= req_count + 1;
            end
        end
    end

    // driver: offers queued requests, with random gaps
    int unsigned src_gap = 0;

    always @(posedge i_clk) begin : driver
        t_req rq;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap != 0) begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                src_gap       <= $urandom_range(0, 6);
                s_axis_tvalid <= 1'b0;
            end else if (req_queue.size() != 0) begin
                rq = req_queue.pop_front();
                s_axis_tdata  <= {rq.blue, rq.green, rq.red, rq.idx};
                s_axis_tuser  <= {rq.fs, rq.cmd};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink: random stalls, plus one long hold-off that lets the job queue fill and
    // back up into the slave side
    int unsigned sink_stall = 0;
    int unsigned sink_hold  = 0;
    bit          hold_done  = 1'b0;

    always @(posedge i_clk) begin : sink
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_hold != 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && req_count >= HOLD_AT) begin
            hold_done     <= 1'b1;
            sink_hold     <= LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_stall != 0) begin
            sink_stall    <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            sink_stall    <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("[palette_pixel_upscaler_top] ERROR");
            $finish;
        end
    end

    function automatic void add_palette(input logic [IDX_W-1:0] idx,
                                        input logic [CHAN_W-1:0] r, g, b, input logic fs);
        t_req rq;
        rq = '{cmd: CMD_PALETTE, fs: fs, idx: idx, red: r, green: g, blue: b};
        req_queue.push_back(rq);
    endfunction

    // colour fields of a pixel request are don't-care, so fill them at random
    function automatic void add_pixel(input logic [IDX_W-1:0] idx, input logic fs);
        t_req rq;
        rq = '{cmd: CMD_PIXEL, fs: fs, idx: idx, red: CHAN_W'($urandom),
               green: CHAN_W'($urandom), blue: CHAN_W'($urandom)};
        req_queue.push_back(rq);
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        return ($urandom_range(0, 1) != 0) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] sw, sh, fw, fh);
        @(posedge i_clk);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_FB_WIDTH, fw);
        write_reg(REG_FB_HEIGHT, fh);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // sender pauses here until every owed run has come back
    task automatic wait_idle();
        @(negedge i_clk);
        while (req_queue.size() != 0 || s_axis_tvalid || owed_runs.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset dimensions (scale 2): palette extremes, unwritten entries, restarts
        add_pixel(8'h00, 1'b1);
        add_palette(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_palette(8'hFF, 8'hAA, 8'h55, 8'h0F, 1'b0);
        add_palette(8'h5A, 8'h55, 8'hAA, 8'hF0, 1'b1);
        add_pixel(8'h00, 1'b0);
        add_pixel(8'hFF, 1'b0);
        add_pixel(8'h5A, 1'b0);
        add_pixel(8'h80, 1'b0);
        add_palette(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pixel(8'h00, 1'b1);
        add_pixel(8'hFF, 1'b0);
        add_pixel(8'hA5, 1'b0);
        wait_idle();

        // zero and oversized registers; tall source in a one-row framebuffer
        set_dims(13'd0, 13'h1FFF, 13'h1FFF, 13'd0);
        add_pixel(8'hFF, 1'b0);
        add_pixel(8'h00, 1'b0);
        add_pixel(8'h5A, 1'b0);
        add_palette(8'h01, 8'h12, 8'h34, 8'h56, 1'b0);
        add_pixel(8'h01, 1'b0);
        add_pixel(8'h01, 1'b0);
        wait_idle();

        // full-width single-row source: row out of range wraps at once
        set_dims(13'd4096, 13'd1, 13'd4096, 13'd4096);
        add_pixel(8'h01, 1'b0);
        add_pixel(8'hFF, 1'b0);
        add_pixel(8'h00, 1'b0);
        add_pixel(8'h5A, 1'b0);
        add_pixel(8'h7E, 1'b0);
        wait_idle();

        // random part: small sources so frames complete often
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0)
                set_dims(13'd5, 13'd3, 13'd17, 13'd13);
            else
                set_dims(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 4)),
                         CFG_W'($urandom_range(1, 50)), CFG_W'($urandom_range(1, 40)));
            if (p == RAND_PHASES - 1)
                idle_on = 1'b0;
            add_pixel(pick_index(), 1'b1);
            for (int n = 1; n < RAND_ITEMS; n++) begin
                if ($urandom_range(0, 9) < 3)
                    add_palette(pick_index(), CHAN_W'($urandom), CHAN_W'($urandom),
                                CHAN_W'($urandom), $urandom_range(0, 7) == 0);
                else
                    add_pixel(pick_index(), $urandom_range(0, 15) == 0);
            end
            wait_idle();
        end

        if (err_cnt == 0)
            $display("[palette_pixel_upscaler_top] OK");
        else
            $display("[palette_pixel_upscaler_top] ERROR");
        $finish;
    end

endmodule
